// ----- rtl/core/disk_ring_alpha_raster_defines.svh -----
// Assertion macros used by the checker file of the disk and ring drawing block.
`ifndef DISK_RING_ALPHA_RASTER_DEFINES_SVH
`define DISK_RING_ALPHA_RASTER_DEFINES_SVH

// A property that must hold at every clock edge outside of reset.
`define DRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must hold in the cycle after its trigger, outside of reset.
`define DRA_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dra_pkg.sv -----
// ----------------------------------------------------------------------------
// Disk and ring raster package
// Sizes, codes, request types and the divide-by-255 helper of the drawing block.
// ----------------------------------------------------------------------------
package dra_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MAX_RADIUS = 63;

	localparam int X_W     = $clog2(MAX_WIDTH);
	localparam int Y_W     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = X_W + Y_W;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int RAD_W   = 6;
	localparam int OFF_W   = RAD_W + 1;
	localparam int COORD_W = 10;
	localparam int SQ_W    = 2 * RAD_W;
	localparam int DIST_W  = SQ_W + 1;
	localparam int CNT_W   = 14;
	localparam int CNT_MAX = 16383;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [31:0] pixel_t;

	typedef enum logic [1:0] {
		CMD_FILL  = 2'd0,
		CMD_RING  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_t;

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_DRAW  = 6'b000100,
		ST_CLEAR = 6'b001000,
		ST_READ  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	typedef struct packed {
		logic   valid;
		addr_t  addr;
		pixel_t dst;
	} blend_req_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		pixel_t data;
	} wr_req_t;

	// Exact floor(v / 255) for every value up to 255 * 255, which covers any
	// blend sum.
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ----- rtl/core/dra_blend.sv -----
// ----------------------------------------------------------------------------
// Source-over blend unit
// Multiplies the stored pixel against the source colour, then divides by 255.
// ----------------------------------------------------------------------------
module dra_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  dra_pkg::blend_req_t req,
	input  dra_pkg::color_t     src,
	output dra_pkg::wr_req_t    wr
);

	logic [7:0]        inv;
	logic              v_s3;
	dra_pkg::addr_t    addr_s3;
	logic [15:0]       sa_s3;
	logic [15:0]       sr_s3;
	logic [15:0]       sg_s3;
	logic [15:0]       sb_s3;

	assign inv = 8'd255 - src.a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= req.valid;
		end
	end

	// Products and sums of each channel; the division follows after the register.
	always_ff @(posedge clk) begin
		addr_s3 <= req.addr;
		sa_s3   <= 16'(req.dst[31:24]) * 16'(inv);
		sr_s3   <= 16'(src.r) * 16'(src.a) + 16'(req.dst[23:16]) * 16'(inv);
		sg_s3   <= 16'(src.g) * 16'(src.a) + 16'(req.dst[15:8]) * 16'(inv);
		sb_s3   <= 16'(src.b) * 16'(src.a) + 16'(req.dst[7:0]) * 16'(inv);
	end

	assign wr.en   = v_s3;
	assign wr.addr = addr_s3;
	assign wr.data = {src.a + dra_pkg::div255(sa_s3), dra_pkg::div255(sr_s3),
		dra_pkg::div255(sg_s3), dra_pkg::div255(sb_s3)};

endmodule

// ----- rtl/core/disk_ring_alpha_raster.sv -----
// ----------------------------------------------------------------------------
// Disk and ring rasterizer with alpha blending
// Draws filled disks and rings into an ARGB frame store, reads and clears it.
// ----------------------------------------------------------------------------
// The block holds a 128 by 128 frame of 32-bit ARGB pixels in one synchronous
// memory. Commands arrive on the input channel (in_valid / in_ready), and every
// command returns exactly one result on the output channel (out_valid /
// out_ready): the pixel read and the count of pixels blended. The canvas size
// registers are written on the cfg channel, which is always ready.
// A fill or ring command scans the whole (2r+1) by (2r+1) box around the center
// with one read-modify-write per cycle, and its result shows once the scan and
// the blend pipeline have drained.
// A read answers from the registered read port, a clear writes zeros one word per
// cycle, and a command that draws nothing goes straight to its result. The next
// request can be taken as soon as the result shows, so one command is in flight
// at a time. After reset the block sweeps zeros through all 16384 words of the
// frame and takes no request during the sweep; configuration writes are still
// taken. A stalled receiver holds the result in the output register, and the
// block may accept and finish work on one more request meanwhile, then waits.
// ----------------------------------------------------------------------------
module disk_ring_alpha_raster (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic signed [8:0] center_x,
	input  logic signed [8:0] center_y,
	input  logic [5:0]        radius,
	input  logic [5:0]        thickness,
	input  logic [7:0]        alpha,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       pixel_value,
	output logic [13:0]       pixels_written
);

	localparam int RAD_W   = dra_pkg::RAD_W;
	localparam int OFF_W   = dra_pkg::OFF_W;
	localparam int COORD_W = dra_pkg::COORD_W;
	localparam int SQ_W    = dra_pkg::SQ_W;
	localparam int DIST_W  = dra_pkg::DIST_W;
	localparam int CNT_W   = dra_pkg::CNT_W;
	localparam int X_W     = dra_pkg::X_W;
	localparam int Y_W     = dra_pkg::Y_W;

	// Frame store and its registered read port.
	dra_pkg::pixel_t mem [dra_pkg::DEPTH];
	dra_pkg::pixel_t rd_data_q;
	dra_pkg::addr_t  rd_addr;
	logic            mem_we;
	dra_pkg::addr_t  mem_wa;
	dra_pkg::pixel_t mem_wd;

	dra_pkg::state_t state_q;
	logic [7:0]      canvas_w_q;
	logic [7:0]      canvas_h_q;
	logic [7:0]      w_eff;
	logic [7:0]      h_eff;

	// Command registers, held for the length of a command.
	logic signed [8:0]  cx_q;
	logic signed [8:0]  cy_q;
	logic [RAD_W-1:0]   rad_q;
	logic [SQ_W-1:0]    outer_sq_q;
	logic [SQ_W-1:0]    inner_sq_q;
	dra_pkg::color_t    color_q;
	logic               rd_ok_q;
	logic [CNT_W-1:0]   count_q;
	dra_pkg::pixel_t    res_pix_q;
	dra_pkg::addr_t     clr_addr_q;

	// Request decode.
	logic                 in_acc;
	logic [RAD_W-1:0]     rad_in;
	logic [RAD_W-1:0]     th_in;
	logic signed [RAD_W:0] diff_in;
	logic [RAD_W-1:0]     inner_in;
	logic                 draw_ok;
	logic                 rd_ok;
	dra_pkg::addr_t       rd_in_addr;
	logic                 clr_last;

	// Box scanner.
	logic                     scan_on_q;
	logic signed [OFF_W-1:0]  dx_q;
	logic signed [OFF_W-1:0]  dy_q;
	logic signed [OFF_W-1:0]  rad_s;
	logic signed [OFF_W-1:0]  rad_in_s;
	logic signed [COORD_W-1:0] x_cur;
	logic signed [COORD_W-1:0] y_cur;
	logic signed [2*OFF_W-1:0] prod_x;
	logic signed [2*OFF_W-1:0] prod_y;

	// Distance test stage.
	logic                      v_s1;
	logic signed [COORD_W-1:0] x_s1;
	logic signed [COORD_W-1:0] y_s1;
	logic [SQ_W-1:0]           sqx_s1;
	logic [SQ_W-1:0]           sqy_s1;
	logic [DIST_W-1:0]         dist_sq;
	logic                      in_x;
	logic                      in_y;
	logic                      hit;
	dra_pkg::addr_t            addr_s1;

	// Read-data stage feeding the blend unit.
	logic                v_s2;
	dra_pkg::addr_t      addr_s2;
	dra_pkg::blend_req_t blend_req;
	dra_pkg::wr_req_t    blend_wr;

	logic       out_valid_q;
	logic [31:0] pixel_value_q;
	logic [13:0] pixels_written_q;
	logic       out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == dra_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Oversized canvas registers act as the full frame.
	assign w_eff = (canvas_w_q > 8'(dra_pkg::MAX_WIDTH)) ? 8'(dra_pkg::MAX_WIDTH) : canvas_w_q;
	assign h_eff = (canvas_h_q > 8'(dra_pkg::MAX_HEIGHT)) ? 8'(dra_pkg::MAX_HEIGHT) : canvas_h_q;

	assign rad_in = (radius > RAD_W'(dra_pkg::MAX_RADIUS)) ? RAD_W'(dra_pkg::MAX_RADIUS) : radius;
	assign th_in  = (thickness > RAD_W'(dra_pkg::MAX_RADIUS)) ?
		RAD_W'(dra_pkg::MAX_RADIUS) : thickness;
	assign diff_in  = signed'({1'b0, rad_in}) - signed'({1'b0, th_in});
	assign inner_in = diff_in[RAD_W] ? '0 : diff_in[RAD_W-1:0];
	assign rad_in_s = signed'({1'b0, rad_in});

	assign draw_ok = ((command == dra_pkg::CMD_FILL) && (rad_in != '0)) ||
		((command == dra_pkg::CMD_RING) && (rad_in != '0) && (th_in != '0));

	// A read outside the active canvas answers zero.
	assign rd_ok = !center_x[8] && !center_y[8] &&
		({1'b0, center_x[7:0]} < {1'b0, w_eff}) &&
		({1'b0, center_y[7:0]} < {1'b0, h_eff});
	assign rd_in_addr = {center_y[Y_W-1:0], center_x[X_W-1:0]};

	assign clr_last = (clr_addr_q == dra_pkg::ADDR_W'(dra_pkg::DEPTH - 1));

	// Scanner coordinates and squared offsets.
	assign rad_s  = signed'({1'b0, rad_q});
	assign x_cur  = {{(COORD_W-9){cx_q[8]}}, cx_q} + {{(COORD_W-OFF_W){dx_q[OFF_W-1]}}, dx_q};
	assign y_cur  = {{(COORD_W-9){cy_q[8]}}, cy_q} + {{(COORD_W-OFF_W){dy_q[OFF_W-1]}}, dy_q};
	assign prod_x = dx_q * dx_q;
	assign prod_y = dy_q * dy_q;

	// Distance and canvas test for the pixel in the first stage.
	assign dist_sq = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
	assign in_x = !x_s1[COORD_W-1] && (x_s1[COORD_W-2:0] < (COORD_W-1)'(w_eff));
	assign in_y = !y_s1[COORD_W-1] && (y_s1[COORD_W-2:0] < (COORD_W-1)'(h_eff));
	assign hit  = v_s1 && in_x && in_y &&
		(dist_sq <= DIST_W'(outer_sq_q)) && (dist_sq >= DIST_W'(inner_sq_q));
	assign addr_s1 = {y_s1[Y_W-1:0], x_s1[X_W-1:0]};

	// The read port serves the read command while idle and the scan otherwise.
	assign rd_addr = (state_q == dra_pkg::ST_IDLE) ? rd_in_addr : addr_s1;

	// Writes come from the clearing sweep or from the blend unit; never both.
	always_comb begin
		if ((state_q == dra_pkg::ST_INIT) || (state_q == dra_pkg::ST_CLEAR)) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else begin
			mem_we = blend_wr.en;
			mem_wa = blend_wr.addr;
			mem_wd = blend_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign blend_req.valid = v_s2;
	assign blend_req.addr  = addr_s2;
	assign blend_req.dst   = rd_data_q;

	dra_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (blend_req),
		.src    (color_q),
		.wr     (blend_wr)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= 8'd128;
			canvas_h_q <= 8'd128;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dra_pkg::REG_WIDTH:  canvas_w_q <= cfg_data;
				dra_pkg::REG_HEIGHT: canvas_h_q <= cfg_data;
				default:             canvas_w_q <= canvas_w_q;
			endcase
		end
	end

	// Command payload captured on acceptance.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q       <= center_x;
			cy_q       <= center_y;
			rad_q      <= rad_in;
			color_q    <= '{a: alpha, r: red, g: green, b: blue};
			rd_ok_q    <= rd_ok;
			outer_sq_q <= SQ_W'(rad_in) * SQ_W'(rad_in);
			inner_sq_q <= (command == dra_pkg::CMD_FILL) ? '0 :
				SQ_W'(inner_in) * SQ_W'(inner_in);
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		x_s1    <= x_cur;
		y_s1    <= y_cur;
		sqx_s1  <= prod_x[SQ_W-1:0];
		sqy_s1  <= prod_y[SQ_W-1:0];
		addr_s2 <= addr_s1;
	end

	// Scanner walks the box row by row, one offset per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_on_q <= 1'b0;
			dx_q      <= '0;
			dy_q      <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			v_s1 <= scan_on_q;
			v_s2 <= hit;
			if (in_acc) begin
				scan_on_q <= draw_ok;
				dx_q      <= -rad_in_s;
				dy_q      <= -rad_in_s;
			end else if (scan_on_q) begin
				if (dx_q == rad_s) begin
					dx_q <= -rad_s;
					if (dy_q == rad_s) begin
						scan_on_q <= 1'b0;
					end else begin
						dy_q <= dy_q + OFF_W'(1);
					end
				end else begin
					dx_q <= dx_q + OFF_W'(1);
				end
			end
		end
	end

	// Sequencer, blended-pixel count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= dra_pkg::ST_INIT;
			clr_addr_q       <= '0;
			count_q          <= '0;
			res_pix_q        <= '0;
			out_valid_q      <= 1'b0;
			pixel_value_q    <= '0;
			pixels_written_q <= '0;
		end else begin
			if (in_acc) begin
				count_q <= '0;
			end else if (hit && (count_q != CNT_W'(dra_pkg::CNT_MAX))) begin
				count_q <= count_q + CNT_W'(1);
			end
			// A finished result moves into the output register once it is free.
			if ((state_q == dra_pkg::ST_DONE) && out_free) begin
				out_valid_q      <= 1'b1;
				pixel_value_q    <= res_pix_q;
				pixels_written_q <= count_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dra_pkg::ST_INIT: begin
					clr_addr_q <= clr_addr_q + dra_pkg::ADDR_W'(1);
					if (clr_last) begin
						state_q <= dra_pkg::ST_IDLE;
					end
				end
				dra_pkg::ST_IDLE: begin
					if (in_acc) begin
						res_pix_q  <= '0;
						clr_addr_q <= '0;
						unique case (command)
							dra_pkg::CMD_FILL,
							dra_pkg::CMD_RING:
								state_q <= draw_ok ? dra_pkg::ST_DRAW : dra_pkg::ST_DONE;
							dra_pkg::CMD_READ:  state_q <= dra_pkg::ST_READ;
							dra_pkg::CMD_CLEAR: state_q <= dra_pkg::ST_CLEAR;
							default:            state_q <= dra_pkg::ST_DONE;
						endcase
					end
				end
				dra_pkg::ST_DRAW: begin
					if (!scan_on_q && !v_s1 && !v_s2 && !blend_wr.en) begin
						state_q <= dra_pkg::ST_DONE;
					end
				end
				dra_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + dra_pkg::ADDR_W'(1);
					if (clr_last) begin
						state_q <= dra_pkg::ST_DONE;
					end
				end
				dra_pkg::ST_READ: begin
					res_pix_q <= rd_ok_q ? rd_data_q : '0;
					state_q   <= dra_pkg::ST_DONE;
				end
				dra_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= dra_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dra_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_value    = pixel_value_q;
	assign pixels_written = pixels_written_q;

endmodule

// ----- rtl/core/dra_checker.sv -----
// ----------------------------------------------------------------------------
// Disk and ring raster port checker
// Watches the ports of the drawing block for handshake and result rules.
// ----------------------------------------------------------------------------
`include "disk_ring_alpha_raster_defines.svh"

module dra_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [31:0]       pixel_value,
	input logic [13:0]       pixels_written
);

	logic stalled;
	logic has_pix;

	assign stalled = out_valid && !out_ready;
	assign has_pix = out_valid && (pixel_value != 32'd0);

	// A stalled result stays offered and unchanged.
	`DRA_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result dropped while stalled")
	`DRA_ASSERT_NEXT(a_out_stable, stalled, $stable({pixel_value, pixels_written}), "result changed")

	// Only one command is worked on at a time.
	`DRA_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready, "request taken while busy")

	// Only reads return pixel data, and reads blend nothing.
	`DRA_ASSERT(a_read_no_count, has_pix |-> (pixels_written == 14'd0), "read with a count")

endmodule

bind disk_ring_alpha_raster dra_checker u_dra_checker (.*);
